// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rdpd_pkg.sv =====
// ---------------------------------------------------------------------------
// rdpd_pkg
// Types, widths and codes shared by the Rice difference pixel decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdpd_pkg;

    localparam int STORE_BITS  = 48;
    localparam int HELD_W      = $clog2(STORE_BITS + 1);
    localparam int WORD_W      = 16;
    localparam int PIX_W       = 16;
    localparam int RAW_W       = 14;
    localparam int K_W         = 3;
    localparam int N_W         = 4;
    localparam int R_W         = 4;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 2;
    localparam int LOW_W       = 1 << K_W;
    localparam int HIGH_W      = 14;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int ESC_RUN     = 8;
    localparam int RUN_SPAN    = ESC_RUN + 1;
    localparam int RUN_W       = $clog2(RUN_SPAN + 1);

    localparam logic [N_W-1:0] CODE_BITS_RESET = N_W'(14);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_RUN,
        ST_NO_DATA,
        ST_MISMATCH
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAW_MODE,
        REG_LOW_BITS,
        REG_CODE_BITS,
        REG_OUT_SHIFT
    } reg_idx_t;

    typedef struct packed {
        logic           raw_mode;
        logic [K_W-1:0] low_bit_count;
        logic [N_W-1:0] code_bit_count;
        logic [R_W-1:0] output_shift;
    } cfg_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RAW,
        CMD_SEED,
        CMD_SEED_END,
        CMD_DROP,
        CMD_CHECK,
        CMD_FILL,
        CMD_FAIL_RUN,
        CMD_FAIL_DATA,
        CMD_APPEND,
        CMD_CODE
    } dp_cmd_t;

    typedef struct packed {
        logic raw_mode;
        logic seed;
        logic check;
        logic fault;
        logic fill_word;
        logic refill_bad;
        logic overflow;
        logic store_empty;
        logic code_wait;
        logic code_bad;
        logic count_full;
        logic slot_free;
    } dp_status_t;

endpackage

// ===== design/rice_difference_pixel_decoder.sv =====
// Sequence: a word is registered on transfer and classified the next cycle; a raw, seed,
//   check or word-level failure result is registered from the classifying state once the
//   output slot is free, and decoded pixels follow once the word is appended to the store.
// Input: a new word is taken only once the current one is finished (in_stall while busy);
//   up to 16 codes are decoded from a word, and output stalls hold the decoder.
// Reset: rst_n asynchronous, clears stream state, fault and output valid, and sets config to its reset values.
// ---------------------------------------------------------------------------
// rice_difference_pixel_decoder
// Rice/Golomb difference decoder with escape codes, raw mode and final check.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rice_difference_pixel_decoder
    import rdpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_W-1:0]    data_word,
    input  logic                 seed_word,
    input  logic                 check_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     pixel,
    output logic                 pixel_valid,
    output logic [STATUS_W-1:0]  status,
    output logic                 packet_end
);

    cfg_t       cfg_reg, cfg_next;
    dp_status_t dp_status;
    dp_cmd_t    cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RAW_MODE:  cfg_next.raw_mode       = cfg_data[0];
                REG_LOW_BITS:  cfg_next.low_bit_count  = cfg_data[K_W-1:0];
                REG_CODE_BITS: cfg_next.code_bit_count = cfg_data[N_W-1:0];
                REG_OUT_SHIFT: cfg_next.output_shift   = cfg_data[R_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_mode       <= 1'b1;
            cfg_reg.low_bit_count  <= '0;
            cfg_reg.code_bit_count <= CODE_BITS_RESET;
            cfg_reg.output_shift   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rdpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    rdpd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .data_word   (data_word),
        .seed_word   (seed_word),
        .check_word  (check_word),
        .out_stall   (out_stall),
        .dp_status   (dp_status),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .status      (status),
        .packet_end  (packet_end),
        .out_valid   (out_valid)
    );

endmodule

// ===== design/rdpd_datapath.sv =====
// ---------------------------------------------------------------------------
// rdpd_datapath
// Bit store, code decoder, pixel accumulator and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdpd_datapath
    import rdpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  dp_cmd_t           cmd,
    input  logic [WORD_W-1:0] data_word,
    input  logic              seed_word,
    input  logic              check_word,
    input  logic              out_stall,
    output dp_status_t        dp_status,
    output logic [PIX_W-1:0]  pixel,
    output logic              pixel_valid,
    output logic [STATUS_W-1:0] status,
    output logic              packet_end,
    output logic              out_valid
);

    logic [STORE_BITS-1:0] store_reg, store_next;
    logic [HELD_W-1:0]     held_reg, held_next;
    logic [PIX_W-1:0]      prev_reg, prev_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    status_t               fault_reg, fault_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]     word_reg;
    logic                  seed_reg;
    logic                  check_reg;
    logic [PIX_W-1:0]      pix_reg, pix_next;
    logic                  pix_valid_reg, pix_valid_next;
    status_t               status_reg, status_next;
    logic                  end_reg, end_next;

    logic [K_W-1:0]    k;
    logic [K_W:0]      k1;
    logic [N_W-1:0]    hw;
    logic [LOW_W-1:0]  low_bits;
    logic              sgn;
    logic [RUN_SPAN-1:0] rest;
    logic [RUN_W-1:0]  first_one;
    logic [RUN_W-1:0]  run_lim;
    logic              short_k;
    logic [HELD_W-1:0] avail;
    logic              escape;
    logic [HELD_W-1:0] used_base;
    logic [HELD_W-1:0] esc_end;
    logic [HELD_W-1:0] used;
    logic [HIGH_W-1:0] esc_bits;
    logic [HIGH_W-1:0] high;
    logic [PIX_W-1:0]  diff;
    logic [PIX_W-1:0]  code_pix;
    logic              code_wait;
    logic              store_empty;
    logic              refill_case;
    logic [HELD_W:0]   zeros;
    logic              refill_bad;
    logic              overflow;
    logic              slot_free;
    status_t           check_status;

    assign k  = cfg.low_bit_count;
    assign k1 = {1'b0, k} + (K_W + 1)'(1);
    assign hw = (cfg.code_bit_count > N_W'(k)) ? cfg.code_bit_count - N_W'(k) : '0;

    assign low_bits = store_reg[LOW_W-1:0] & ((LOW_W'(1) << k) - LOW_W'(1));
    assign sgn      = store_reg[k];
    assign rest     = RUN_SPAN'(store_reg >> k1);

    always_comb
    begin
        first_one = RUN_W'(RUN_SPAN);
        for (int i = RUN_SPAN - 1; i >= 0; i--)
        begin
            if (rest[i])
            begin
                first_one = RUN_W'(i);
            end
        end
    end

    assign run_lim   = (first_one > RUN_W'(ESC_RUN)) ? RUN_W'(ESC_RUN) : first_one;
    assign short_k   = held_reg < HELD_W'(k1);
    assign avail     = held_reg - HELD_W'(k1);
    assign escape    = first_one == RUN_W'(ESC_RUN);
    assign used_base = HELD_W'(k1) + HELD_W'(first_one) + HELD_W'(1);
    assign esc_end   = used_base + HELD_W'(hw);
    assign used      = escape ? esc_end : used_base;
    assign code_wait = short_k || (avail <= HELD_W'(run_lim))
                       || (escape && (esc_end > held_reg));

    assign esc_bits = HIGH_W'(store_reg >> used_base)
                      & HIGH_W'((HIGH_W'(1) << hw) - HIGH_W'(1));
    assign high     = escape ? esc_bits : HIGH_W'(first_one);
    assign diff     = (PIX_W'(high) << k) + PIX_W'(low_bits);
    assign code_pix = sgn ? prev_reg - diff : prev_reg + diff;

    assign store_empty = store_reg == '0;
    assign refill_case = store_empty && (fill_reg != '0);
    assign zeros       = {1'b0, held_reg} + ((HELD_W + 1)'(fill_reg) << 4);
    assign refill_bad  = refill_case
                         && (zeros >= (HELD_W + 1)'(k1) + (HELD_W + 1)'(RUN_SPAN));
    assign overflow    = !refill_case
                         && ({1'b0, held_reg} + (HELD_W + 1)'(WORD_W)
                             > (HELD_W + 1)'(STORE_BITS));

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (!store_empty)
        begin
            check_status = ST_NO_DATA;
        end
        else if (prev_reg != word_reg)
        begin
            check_status = ST_MISMATCH;
        end
        else
        begin
            check_status = ST_OK;
        end
    end

    always_comb
    begin
        dp_status.raw_mode    = cfg.raw_mode;
        dp_status.seed        = seed_reg;
        dp_status.check       = check_reg;
        dp_status.fault       = fault_reg != ST_OK;
        dp_status.fill_word   = store_empty && (word_reg == '0);
        dp_status.refill_bad  = refill_bad;
        dp_status.overflow    = overflow;
        dp_status.store_empty = store_empty;
        dp_status.code_wait   = code_wait;
        dp_status.code_bad    = !code_wait && (first_one == RUN_W'(RUN_SPAN));
        dp_status.count_full  = count_reg >= CNT_W'(MAX_RESULTS);
        dp_status.slot_free   = slot_free;
    end

    always_comb
    begin
        store_next     = store_reg;
        held_next      = held_reg;
        prev_next      = prev_reg;
        fill_next      = fill_reg;
        fault_next     = fault_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        pix_next       = pix_reg;
        pix_valid_next = pix_valid_reg;
        status_next    = status_reg;
        end_next       = end_reg;
        unique case (cmd)
            CMD_NONE:
            begin
            end
            CMD_LOAD:
            begin
                count_next = '0;
            end
            CMD_RAW:
            begin
                out_valid_next = 1'b1;
                pix_next       = PIX_W'(word_reg[RAW_W-1:0]);
                pix_valid_next = 1'b1;
                status_next    = ST_OK;
                end_next       = check_reg;
            end
            CMD_SEED:
            begin
                store_next     = '0;
                held_next      = '0;
                fill_next      = '0;
                fault_next     = ST_OK;
                prev_next      = word_reg;
                out_valid_next = 1'b1;
                pix_next       = PIX_W'(word_reg << cfg.output_shift);
                pix_valid_next = 1'b1;
                status_next    = ST_OK;
                end_next       = 1'b0;
            end
            CMD_SEED_END:
            begin
                out_valid_next = 1'b1;
                pix_next       = '0;
                pix_valid_next = 1'b0;
                status_next    = ST_OK;
                end_next       = 1'b1;
            end
            CMD_DROP:
            begin
                if (check_reg)
                begin
                    fault_next = ST_OK;
                    store_next = '0;
                    held_next  = '0;
                    fill_next  = '0;
                end
            end
            CMD_CHECK:
            begin
                out_valid_next = 1'b1;
                pix_next       = '0;
                pix_valid_next = 1'b0;
                status_next    = check_status;
                end_next       = 1'b1;
                store_next     = '0;
                held_next      = '0;
                fill_next      = '0;
                fault_next     = ST_OK;
            end
            CMD_FILL:
            begin
                if (fill_reg != '1)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            CMD_FAIL_RUN, CMD_FAIL_DATA:
            begin
                out_valid_next = 1'b1;
                pix_next       = '0;
                pix_valid_next = 1'b0;
                status_next    = (cmd == CMD_FAIL_RUN) ? ST_BAD_RUN : ST_NO_DATA;
                end_next       = 1'b1;
                fault_next     = (cmd == CMD_FAIL_RUN) ? ST_BAD_RUN : ST_NO_DATA;
                store_next     = '0;
                held_next      = '0;
                fill_next      = '0;
            end
            CMD_APPEND:
            begin
                if (refill_case)
                begin
                    store_next = STORE_BITS'(word_reg) << zeros;
                    held_next  = HELD_W'(zeros + (HELD_W + 1)'(WORD_W));
                    fill_next  = '0;
                end
                else
                begin
                    store_next = store_reg | (STORE_BITS'(word_reg) << held_reg);
                    held_next  = held_reg + HELD_W'(WORD_W);
                end
            end
            CMD_CODE:
            begin
                prev_next      = code_pix;
                store_next     = store_reg >> used;
                held_next      = held_reg - used;
                count_next     = count_reg + CNT_W'(1);
                out_valid_next = 1'b1;
                pix_next       = PIX_W'(code_pix << cfg.output_shift);
                pix_valid_next = 1'b1;
                status_next    = ST_OK;
                end_next       = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg     <= '0;
            held_reg      <= '0;
            prev_reg      <= '0;
            fill_reg      <= '0;
            fault_reg     <= ST_OK;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            store_reg     <= store_next;
            held_reg      <= held_next;
            prev_reg      <= prev_next;
            fill_reg      <= fill_next;
            fault_reg     <= fault_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD)
        begin
            word_reg  <= data_word;
            seed_reg  <= seed_word;
            check_reg <= check_word;
        end
        pix_reg       <= pix_next;
        pix_valid_reg <= pix_valid_next;
        status_reg    <= status_next;
        end_reg       <= end_next;
    end

    assign pixel       = pix_reg;
    assign pixel_valid = pix_valid_reg;
    assign status      = status_reg;
    assign packet_end  = end_reg;
    assign out_valid   = out_valid_reg;

endmodule

// ===== design/rdpd_ctrl.sv =====
// ---------------------------------------------------------------------------
// rdpd_ctrl
// Sequencer: classifies each word, then steps the decoder one code a cycle while the output slot is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdpd_ctrl
    import rdpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t dp_status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORD,
        S_DECODE,
        S_SEED_END
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_WORD;
                end
            end
            S_WORD:
            begin
                priority if (dp_status.raw_mode)
                begin
                    if (dp_status.slot_free)
                    begin
                        cmd        = CMD_RAW;
                        state_next = S_IDLE;
                    end
                end
                else if (dp_status.seed)
                begin
                    if (dp_status.slot_free)
                    begin
                        cmd        = CMD_SEED;
                        state_next = dp_status.check ? S_SEED_END : S_IDLE;
                    end
                end
                else if (dp_status.fault)
                begin
                    cmd        = CMD_DROP;
                    state_next = S_IDLE;
                end
                else if (dp_status.check)
                begin
                    if (dp_status.slot_free)
                    begin
                        cmd        = CMD_CHECK;
                        state_next = S_IDLE;
                    end
                end
                else if (dp_status.fill_word)
                begin
                    cmd        = CMD_FILL;
                    state_next = S_IDLE;
                end
                else if (dp_status.refill_bad || dp_status.overflow)
                begin
                    if (dp_status.slot_free)
                    begin
                        cmd        = dp_status.refill_bad ? CMD_FAIL_RUN : CMD_FAIL_DATA;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd        = CMD_APPEND;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (dp_status.store_empty || dp_status.count_full
                             || dp_status.code_wait)
                begin
                    state_next = S_IDLE;
                end
                else if (dp_status.slot_free)
                begin
                    cmd = dp_status.code_bad ? CMD_FAIL_RUN : CMD_CODE;
                    if (dp_status.code_bad)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd = CMD_NONE;
                end
            end
            S_SEED_END:
            begin
                if (dp_status.slot_free)
                begin
                    cmd        = CMD_SEED_END;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

// ===== design/rdpd_checker.sv =====
// ---------------------------------------------------------------------------
// rdpd_checker
// Port-level checks on the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdpd_checker
    import rdpd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [PIX_W-1:0]    pixel,
    input logic                pixel_valid,
    input logic [STATUS_W-1:0] status,
    input logic                packet_end
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pixel) && $stable(status) && $stable(packet_end), "stalled result changed")
    `ASSERT_IMPLY(a_status_item_zero, clk, rst_n, out_valid && !pixel_valid, pixel == '0, "status-only item carries a pixel")
    `ASSERT_IMPLY(a_error_ends_packet, clk, rst_n, out_valid && (status != ST_OK), packet_end && !pixel_valid, "error result not a packet end")
    `ASSERT_NEXT(a_one_word_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "second word taken while busy")

endmodule

bind rice_difference_pixel_decoder rdpd_checker u_rdpd_checker (.*);

// ===== dv/tb_rice_difference_pixel_decoder.sv =====
// ---------------------------------------------------------------------------
// tb_rice_difference_pixel_decoder
// Self-checking bench: a clocked driver feeds packet words from a queue, a
// clocked monitor predicts the pixels and status items of every accepted word
// and compares each output transfer against the oldest prediction. Stimulus
// is a directed set of corner packets followed by random coded packets (good,
// mismatched, cut short, bad zero runs, fill words), raw words and noise,
// under several register settings with random idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rice_difference_pixel_decoder;
    import rdpd_pkg::*;

    localparam int RANDOM_WORDS = 230;
    localparam int PHASE_WORDS  = 26;
    localparam int SETTLE       = 24;
    localparam int LONG_HOLD    = 300;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is_seed;
        logic              is_check;
    } word_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             has_pix;
        status_t          st;
        logic             last;
    } pixel_result_t;

    typedef enum {END_GOOD, END_MISMATCH, END_CUT, END_BAD_RUN} ending_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [WORD_W-1:0]    data_word = '0;
    logic                 seed_word = 1'b0;
    logic                 check_word = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PIX_W-1:0]     pixel;
    logic                 pixel_valid;
    logic [STATUS_W-1:0]  status;
    logic                 packet_end;

    rice_difference_pixel_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .seed_word  (seed_word),
        .check_word (check_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel      (pixel),
        .pixel_valid(pixel_valid),
        .status     (status),
        .packet_end (packet_end)
    );

    word_item_t    word_feed_q[$];
    pixel_result_t pixel_expect_q[$];

    // predictor state and its copy of the registers
    logic [63:0]  m_store;
    int unsigned  m_held;
    logic [15:0]  m_prev;
    int unsigned  m_zero_words;
    status_t      m_fault;
    bit           m_raw;
    int unsigned  m_k;
    int unsigned  m_n;
    int unsigned  m_r;
    int           step_results;

    int           words_pushed = 0;
    int           words_accepted = 0;
    int           results_checked = 0;
    int           pixels_expected = 0;
    int           status_count[4];
    int           mismatches = 0;
    int           configs_used = 0;

    logic         in_fire = 1'b0;
    word_item_t   drive_item;
    word_item_t   seen_item;
    int           send_gap = 0;
    int           stall_left = 0;
    int           long_hold_left = 0;
    int           hold_requests = 0;
    int           hold_served = 0;
    bit           quiet_in = 1'b0;
    bit           quiet_out = 1'b0;

    logic [15:0]  pack_word;
    int           pack_bits;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [15:0] scale(logic [15:0] v);
        return 16'(v << m_r);
    endfunction

    task automatic queue_result(logic [15:0] p, logic hp, status_t s, logic e);
        pixel_result_t r;
        r.pix = p;
        r.has_pix = hp;
        r.st = s;
        r.last = e;
        pixel_expect_q.push_back(r);
        step_results++;
        if (hp)
            pixels_expected++;
        else
            status_count[s]++;
    endtask

    task automatic clear_stream();
        m_store = '0;
        m_held = 0;
        m_zero_words = 0;
    endtask

    task automatic fail_packet(status_t s);
        queue_result('0, 1'b0, s, 1'b1);
        m_fault = s;
        clear_stream();
    endtask

    task automatic decode_codes();
        int unsigned k1, avail, run, used, hw, high, low, i;
        logic        sgn;
        logic [63:0] rest;
        logic [15:0] diff;
        hw = (m_n > m_k) ? m_n - m_k : 0;
        k1 = m_k + 1;
        while (m_store != 0 && step_results < MAX_RESULTS)
        begin
            if (m_held < k1)
                return;
            low = 32'(m_store & ((64'd1 << m_k) - 64'd1));
            sgn = m_store[m_k];
            rest = m_store >> k1;
            avail = m_held - k1;
            run = RUN_SPAN;
            for (i = 0; i < RUN_SPAN; i++)
            begin
                if (i >= avail)
                    return;
                if (rest[i])
                begin
                    run = i;
                    break;
                end
            end
            if (run == RUN_SPAN)
            begin
                fail_packet(ST_BAD_RUN);
                return;
            end
            used = k1 + run + 1;
            if (run == ESC_RUN)
            begin
                if (used + hw > m_held)
                    return;
                high = 32'((m_store >> used) & ((64'd1 << hw) - 64'd1));
                used += hw;
            end
            else
            begin
                high = run;
            end
            diff = 16'((high << m_k) + low);
            m_prev = sgn ? m_prev - diff : m_prev + diff;
            queue_result(scale(m_prev), 1'b1, ST_OK, 1'b0);
            m_store = m_store >> used;
            m_held -= used;
        end
    endtask

    task automatic decode_word(word_item_t it);
        int unsigned zeros;
        status_t     st;
        step_results = 0;
        if (m_raw)
        begin
            queue_result({2'b00, it.word[RAW_W-1:0]}, 1'b1, ST_OK, it.is_check);
            return;
        end
        if (it.is_seed)
        begin
            clear_stream();
            m_fault = ST_OK;
            m_prev = it.word;
            queue_result(scale(it.word), 1'b1, ST_OK, 1'b0);
            if (it.is_check)
                queue_result('0, 1'b0, ST_OK, 1'b1);
            return;
        end
        if (m_fault != ST_OK)
        begin
            if (it.is_check)
            begin
                m_fault = ST_OK;
                clear_stream();
            end
            return;
        end
        if (it.is_check)
        begin
            st = ST_OK;
            if (m_store != 0)
                st = ST_NO_DATA;
            else if (m_prev != it.word)
                st = ST_MISMATCH;
            queue_result('0, 1'b0, st, 1'b1);
            clear_stream();
            m_fault = ST_OK;
            return;
        end
        if (m_store == 0 && it.word == 0)
        begin
            if (m_zero_words < 3)
                m_zero_words++;
            return;
        end
        if (m_store == 0 && m_zero_words != 0)
        begin
            zeros = m_held + 16 * m_zero_words;
            if (zeros >= m_k + 10)
            begin
                fail_packet(ST_BAD_RUN);
                return;
            end
            m_store = 64'(it.word) << zeros;
            m_held = zeros + 16;
            m_zero_words = 0;
        end
        else
        begin
            if (m_held + 16 > STORE_BITS)
            begin
                fail_packet(ST_NO_DATA);
                return;
            end
            m_store = m_store | (64'(it.word) << m_held);
            m_held += 16;
        end
        decode_codes();
    endtask

    // ---------------- checking ----------------

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_result();
        pixel_result_t want;
        results_checked++;
        if (pixel_expect_q.size() == 0)
        begin
            note_failure($sformatf("unexpected result pixel=%h pv=%b status=%0d end=%b",
                                   pixel, pixel_valid, status, packet_end));
            return;
        end
        want = pixel_expect_q.pop_front();
        if (pixel !== want.pix || pixel_valid !== want.has_pix || status !== want.st ||
            packet_end !== want.last)
            note_failure($sformatf({"exp pixel=%h pv=%b status=%0d end=%b, ",
                                    "got pixel=%h pv=%b status=%0d end=%b"},
                                   want.pix, want.has_pix, want.st, want.last,
                                   pixel, pixel_valid, status, packet_end));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                seen_item.word = data_word;
                seen_item.is_seed = seed_word;
                seen_item.is_check = check_word;
                decode_word(seen_item);
                words_accepted++;
            end
            if (out_valid && !out_stall)
                check_result();
        end
    end

    // ---------------- driving ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (word_feed_q.size() != 0)
            begin
                drive_item = word_feed_q.pop_front();
                data_word <= drive_item.word;
                seed_word <= drive_item.is_seed;
                check_word <= drive_item.is_check;
                in_valid <= 1'b1;
                send_gap = quiet_in ? 0 : pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (long_hold_left > 0)
        begin
            out_stall <= 1'b1;
            long_hold_left--;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served++;
            long_hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet_out && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_word(logic [15:0] w, bit s, bit c);
        word_item_t it;
        it.word = w;
        it.is_seed = s;
        it.is_check = c;
        word_feed_q.push_back(it);
        words_pushed++;
    endtask

    task automatic put_bits(logic [31:0] v, int cnt);
        for (int i = 0; i < cnt; i++)
        begin
            pack_word[pack_bits] = v[i];
            pack_bits++;
            if (pack_bits == 16)
            begin
                push_word(pack_word, 1'b0, 1'b0);
                pack_word = '0;
                pack_bits = 0;
            end
        end
    endtask

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hffff;
        return 16'($urandom);
    endfunction

    task automatic push_noise();
        push_word($urandom_range(0, 1) ? pick_word() : 16'h0000,
                  $urandom_range(0, 6) == 0, $urandom_range(0, 6) == 0);
    endtask

    task automatic coded_packet(int n_codes, ending_t ending);
        int          hw, high, low;
        bit          sgn, esc;
        logic [15:0] last_pix;
        logic [15:0] diff;
        hw = (m_n > m_k) ? m_n - m_k : 0;
        last_pix = pick_word();
        push_word(last_pix, 1'b1, 1'b0);
        pack_word = '0;
        pack_bits = 0;
        repeat (n_codes)
        begin
            low = $urandom_range(0, (1 << m_k) - 1);
            sgn = $urandom_range(0, 1);
            esc = $urandom_range(0, 3) == 0;
            if (esc)
                high = (hw == 0) ? 0 : ($urandom_range(0, 9) == 0) ? (1 << hw) - 1
                                                                   : $urandom_range(0, (1 << hw) - 1);
            else
                high = $urandom_range(0, ESC_RUN - 1);
            put_bits(32'(low), m_k);
            put_bits(32'(sgn), 1);
            if (esc)
            begin
                put_bits(0, ESC_RUN);
                put_bits(1, 1);
                put_bits(32'(high), hw);
            end
            else
            begin
                put_bits(0, high);
                put_bits(1, 1);
            end
            diff = 16'((high << m_k) + low);
            last_pix = sgn ? last_pix - diff : last_pix + diff;
        end
        if (ending == END_BAD_RUN)
        begin
            put_bits($urandom, m_k + 1);
            put_bits(0, RUN_SPAN);
            put_bits(1, 1);
        end
        else if (ending == END_CUT)
        begin
            put_bits($urandom, m_k);
            put_bits(1, 1);
            put_bits(0, ESC_RUN);
            put_bits(1, 1);
            put_bits($urandom, (hw > 0) ? $urandom_range(0, hw - 1) : 0);
        end
        if (pack_bits > 0)
            put_bits(0, 16 - pack_bits);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) push_word(16'h0000, 1'b0, 1'b0);
        if (ending == END_BAD_RUN)
            repeat ($urandom_range(0, 2)) push_word(pick_word(), 1'b0, 1'b0);
        if (ending == END_MISMATCH)
            last_pix = last_pix ^ 16'($urandom_range(1, 65535));
        push_word(last_pix, 1'b0, 1'b1);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(bit raw, int unsigned k, int unsigned n, int unsigned r);
        write_reg(REG_RAW_MODE, CFG_W'(raw));
        write_reg(REG_LOW_BITS, CFG_W'(k));
        write_reg(REG_CODE_BITS, CFG_W'(n));
        write_reg(REG_OUT_SHIFT, CFG_W'(r));
        m_raw = raw;
        m_k = k;
        m_n = n;
        m_r = r;
        configs_used++;
    endtask

    task automatic wait_drained();
        while (words_accepted != words_pushed || pixel_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int      random_start, phase_start, phase_no, r;
        ending_t ending;

        for (int i = 0; i < 4; i++)
            status_count[i] = 0;
        m_raw = 1'b1;
        m_k = 0;
        m_n = CODE_BITS_RESET;
        m_r = 0;
        m_prev = '0;
        m_fault = ST_OK;
        clear_stream();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // raw words under the reset settings
        push_word(16'h0000, 1'b0, 1'b0);
        push_word(16'hffff, 1'b1, 1'b1);
        push_word(16'hc000, 1'b0, 1'b1);
        push_word(16'h3fff, 1'b1, 1'b0);
        wait_drained();

        set_config(1'b0, 0, 14, 0);
        push_word(16'haaaa, 1'b0, 1'b0);    // codes before any seed
        push_word(16'h0000, 1'b0, 1'b1);
        push_word(16'h0000, 1'b1, 1'b1);    // seed that is also the final word
        push_word(16'hffff, 1'b1, 1'b0);    // escape left unfinished
        push_word(16'h0201, 1'b0, 1'b0);
        push_word(16'h0000, 1'b0, 1'b1);
        push_word(16'h1234, 1'b1, 1'b0);    // zero run too long, rest dropped
        push_word(16'h0001, 1'b0, 1'b0);
        push_word(16'hffff, 1'b0, 1'b0);
        push_word(16'h1234, 1'b0, 1'b1);
        push_word(16'h0010, 1'b1, 1'b0);    // trailing fill words
        push_word(16'h0000, 1'b0, 1'b0);
        push_word(16'h0000, 1'b0, 1'b0);
        push_word(16'h0010, 1'b0, 1'b1);
        push_word(16'h0000, 1'b1, 1'b0);    // zero words then a one: too long
        push_word(16'h0000, 1'b0, 1'b0);
        push_word(16'h0001, 1'b0, 1'b0);
        push_word(16'h0000, 1'b0, 1'b1);
        push_word(16'h0005, 1'b1, 1'b0);    // final word mismatch
        push_word(16'h0006, 1'b0, 1'b1);
        wait_drained();

        random_start = words_pushed;
        phase_no = 0;
        while (words_pushed - random_start < RANDOM_WORDS)
        begin
            case (phase_no)
                0: set_config(1'b0, 7, 14, 15);
                1: set_config(1'b0, 7, 1, 3);
                2: set_config(1'b0, 0, 1, 8);
                3: set_config(1'b1, 5, 9, 6);
                default: set_config($urandom_range(0, 5) == 0, $urandom_range(0, 7),
                                    $urandom_range(1, 14), $urandom_range(0, 15));
            endcase
            quiet_in = (phase_no == 0) || ($urandom_range(0, 4) == 0);
            quiet_out = $urandom_range(0, 4) == 0;
            phase_start = words_pushed;
            while (words_pushed - phase_start < PHASE_WORDS)
            begin
                r = $urandom_range(0, 99);
                if (m_raw)
                begin
                    push_word(16'($urandom), $urandom_range(0, 4) == 0,
                              $urandom_range(0, 4) == 0);
                end
                else if (r < 12)
                begin
                    push_noise();
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    ending = (r < 60) ? END_GOOD : (r < 72) ? END_MISMATCH :
                             (r < 86) ? END_CUT : END_BAD_RUN;
                    coded_packet(($urandom_range(0, 9) == 0) ? $urandom_range(7, 14)
                                                             : $urandom_range(1, 6), ending);
                end
            end
            // output held off long enough that the decoder backs up into its input
            if (phase_no == 0)
                hold_requests++;
            wait_drained();
            phase_no++;
        end

        $display("Summary: %0d words over %0d register settings, %0d results compared, %0d pixels",
                 words_accepted, configs_used, results_checked, pixels_expected);
        $display("Status items: ok %0d, bad zero run %0d, out of data %0d, final mismatch %0d",
                 status_count[ST_OK], status_count[ST_BAD_RUN], status_count[ST_NO_DATA],
                 status_count[ST_MISMATCH]);
        if (mismatches == 0 && pixel_expect_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
